// ----- design/bnet_pkg.sv -----
// ----------------------------------------------------------------------------
// bnet_pkg
// Shared types and constants for the catalog node extent translator.
// ----------------------------------------------------------------------------
`default_nettype none

package bnet_pkg;

    localparam int EXTENT_SLOTS = 8;
    localparam int SLOT_W       = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;

    localparam int BLK_SIZE_LOG2_MIN = 9;
    localparam int BLK_SIZE_LOG2_MAX = 20;
    localparam int ILLEGAL_BIT       = 28;

    localparam int PROD_W   = 48;
    localparam int BLK_W    = PROD_W - BLK_SIZE_LOG2_MIN;
    localparam int INBLK_W  = BLK_SIZE_LOG2_MAX;
    localparam int REAL_W   = 33;
    localparam int OFF_W    = REAL_W + BLK_SIZE_LOG2_MAX;
    localparam int BSIZE_W  = BLK_SIZE_LOG2_MAX + 1;
    localparam int CFG_ADDR_W = 3;

    localparam logic FUNC_WRITE_SLOT = 1'b0;
    localparam logic FUNC_TRANSLATE  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_NODES     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_SIZE       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_SIZE_LOG2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CATALOG_BLOCKS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_BLOCKS   = 3'd4;

    typedef enum logic [3:0] {
        STAT_OK                 = 4'd0,
        STAT_NODE_RANGE         = 4'd1,
        STAT_BEYOND_FORK        = 4'd2,
        STAT_EMPTY_EXTENT       = 4'd3,
        STAT_ILLEGAL_EXTENT     = 4'd4,
        STAT_NOT_IN_EXTENTS     = 4'd5,
        STAT_PAST_VOLUME        = 4'd6,
        STAT_NODE_EXCEEDS_BLOCK = 4'd7,
        STAT_ZERO_OFFSET        = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_WALK,
        ST_CHECK,
        ST_OFFSET,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] count;
    } extent_t;

endpackage

`default_nettype wire

// ----- design/btree_node_extent_translator.sv -----
// ----------------------------------------------------------------------------
// btree_node_extent_translator
// Locates a catalog B-tree node on the volume through an eight-slot extent map.
// ----------------------------------------------------------------------------
// A transaction with func 0 loads one extent slot; its status 0 result goes
// through the done state to the output register once the output is free. A
// transaction with func 1 translates a node number into a volume byte offset;
// node range and node size errors go straight to the done state, while other
// lookups run through the multiply, split, walk, check and offset states,
// stopping early on an error. The sequencer examines one extent slot per
// cycle with a single compare and subtract unit. The block accepts one
// transaction at a time and is ready again in the cycle after the result is
// handed to the output register.
`default_nettype none

module btree_node_extent_translator
    import bnet_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]           cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_func,
    input  wire logic [2:0]            s_slot_index,
    input  wire logic [31:0]           s_slot_start,
    input  wire logic [31:0]           s_slot_count,
    input  wire logic [31:0]           s_node_number,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [3:0]                 m_status,
    output logic [51:0]                m_byte_offset,
    output logic [2:0]                 m_extent_used,
    output logic [31:0]                m_volume_block
);

    logic [31:0] total_nodes_reg;
    logic [15:0] node_size_reg;
    logic [4:0]  block_size_log2_reg;
    logic [31:0] catalog_blocks_reg;
    logic [31:0] volume_blocks_reg;

    state_t              state_reg, state_next;
    logic [31:0]         node_reg, node_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [INBLK_W-1:0]  inblk_reg, inblk_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [REAL_W-1:0]   real_reg, real_next;
    status_t             res_status_reg, res_status_next;
    logic [51:0]         res_offset_reg, res_offset_next;
    logic [2:0]          res_used_reg, res_used_next;
    logic [31:0]         res_vblock_reg, res_vblock_next;

    logic                m_valid_reg, m_valid_next;
    logic [3:0]          m_status_reg, m_status_next;
    logic [51:0]         m_offset_reg, m_offset_next;
    logic [2:0]          m_used_reg, m_used_next;
    logic [31:0]         m_vblock_reg, m_vblock_next;

    logic [4:0]          lg_sat;
    logic [BSIZE_W-1:0]  bsize;
    logic [OFF_W-1:0]    off_sum;
    logic                accept;
    logic                tbl_wr_en;
    extent_t             tbl_wr_data;
    extent_t             ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_nodes_reg     <= '0;
            node_size_reg       <= 16'd4096;
            block_size_log2_reg <= 5'd12;
            catalog_blocks_reg  <= '0;
            volume_blocks_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TOTAL_NODES:     total_nodes_reg     <= cfg_wdata;
                CFG_NODE_SIZE:       node_size_reg       <= cfg_wdata[15:0];
                CFG_BLOCK_SIZE_LOG2: block_size_log2_reg <= cfg_wdata[4:0];
                CFG_CATALOG_BLOCKS:  catalog_blocks_reg  <= cfg_wdata;
                CFG_VOLUME_BLOCKS:   volume_blocks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (block_size_log2_reg < 5'(BLK_SIZE_LOG2_MIN)) begin
            lg_sat = 5'(BLK_SIZE_LOG2_MIN);
        end else if (block_size_log2_reg > 5'(BLK_SIZE_LOG2_MAX)) begin
            lg_sat = 5'(BLK_SIZE_LOG2_MAX);
        end else begin
            lg_sat = block_size_log2_reg;
        end
    end

    assign bsize   = BSIZE_W'(1) << lg_sat;
    assign off_sum = (OFF_W'(real_reg) << lg_sat) + OFF_W'(inblk_reg);

    assign accept      = s_valid && s_ready;
    assign tbl_wr_en   = accept && (s_func == FUNC_WRITE_SLOT)
                         && (32'(s_slot_index) < 32'(EXTENT_SLOTS));
    assign tbl_wr_data = '{start: s_slot_start, count: s_slot_count};

    bnet_ext_table u_ext_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (SLOT_W'(s_slot_index)),
        .wr_data (tbl_wr_data),
        .rd_addr (slot_reg),
        .rd_data (ext)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        node_reg       <= node_next;
        prod_reg       <= prod_next;
        blk_reg        <= blk_next;
        inblk_reg      <= inblk_next;
        slot_reg       <= slot_next;
        real_reg       <= real_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_used_reg   <= res_used_next;
        res_vblock_reg <= res_vblock_next;
        m_status_reg   <= m_status_next;
        m_offset_reg   <= m_offset_next;
        m_used_reg     <= m_used_next;
        m_vblock_reg   <= m_vblock_next;
    end

    always_comb begin
        state_next      = state_reg;
        node_next       = node_reg;
        prod_next       = prod_reg;
        blk_next        = blk_reg;
        inblk_next      = inblk_reg;
        slot_next       = slot_reg;
        real_next       = real_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_used_next   = res_used_reg;
        res_vblock_next = res_vblock_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_offset_next   = m_offset_reg;
        m_used_next     = m_used_reg;
        m_vblock_next   = m_vblock_reg;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    node_next       = s_node_number;
                    slot_next       = '0;
                    res_status_next = STAT_OK;
                    res_offset_next = '0;
                    res_used_next   = '0;
                    res_vblock_next = '0;
                    if (s_func == FUNC_WRITE_SLOT) begin
                        state_next = ST_DONE;
                    end else if (s_node_number >= total_nodes_reg) begin
                        res_status_next = STAT_NODE_RANGE;
                        state_next      = ST_DONE;
                    end else if (BSIZE_W'(node_size_reg) > bsize) begin
                        res_status_next = STAT_NODE_EXCEEDS_BLOCK;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(node_reg) * PROD_W'(node_size_reg);
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                blk_next   = BLK_W'(prod_reg >> lg_sat);
                inblk_next = INBLK_W'(prod_reg) & INBLK_W'(bsize - BSIZE_W'(1));
                if (BLK_W'(prod_reg >> lg_sat) >= BLK_W'(catalog_blocks_reg)) begin
                    res_status_next = STAT_BEYOND_FORK;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (ext.start == '0 || ext.count == '0) begin
                    res_status_next = STAT_EMPTY_EXTENT;
                    state_next      = ST_DONE;
                end else if (ext.start[ILLEGAL_BIT] && ext.count[ILLEGAL_BIT]) begin
                    res_status_next = STAT_ILLEGAL_EXTENT;
                    state_next      = ST_DONE;
                end else if (blk_reg < BLK_W'(ext.count)) begin
                    real_next  = REAL_W'(ext.start) + REAL_W'(blk_reg[31:0]);
                    state_next = ST_CHECK;
                end else begin
                    blk_next = blk_reg - BLK_W'(ext.count);
                    if (slot_reg == SLOT_W'(EXTENT_SLOTS - 1)) begin
                        res_status_next = STAT_NOT_IN_EXTENTS;
                        state_next      = ST_DONE;
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            ST_CHECK: begin
                if (real_reg >= REAL_W'(volume_blocks_reg)) begin
                    res_status_next = STAT_PAST_VOLUME;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                if (off_sum == '0) begin
                    res_status_next = STAT_ZERO_OFFSET;
                end else begin
                    res_offset_next = off_sum[51:0];
                    res_used_next   = 3'(slot_reg);
                    res_vblock_next = real_reg[31:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_offset_next = res_offset_reg;
                    m_used_next   = res_used_reg;
                    m_vblock_next = res_vblock_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_byte_offset  = m_offset_reg;
    assign m_extent_used  = m_used_reg;
    assign m_volume_block = m_vblock_reg;

endmodule

`default_nettype wire

// ----- design/bnet_ext_table.sv -----
// ----------------------------------------------------------------------------
// bnet_ext_table
// Extent slot table with one write port and one read port, cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bnet_ext_table
    import bnet_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire extent_t           wr_data,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output extent_t                rd_data
);

    extent_t slot_reg [EXTENT_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < EXTENT_SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (wr_en) begin
            slot_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_addr];

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the catalog node extent translator. A short table
// of directed transactions covers the register extremes and every status
// code but STAT_ZERO_OFFSET. Random batches follow, each under a fresh
// register setting, mostly loading sane extent maps and looking up nodes in
// them. Every result is checked field by field against answers kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bnet_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int BATCHES       = 7;
    localparam int BATCH_ITEMS   = 52;

    typedef struct packed {
        logic        func;
        logic [2:0]  slot_index;
        logic [31:0] slot_start;
        logic [31:0] slot_count;
        logic [31:0] node_number;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [51:0] byte_offset;
        logic [2:0]  extent_used;
        logic [31:0] volume_block;
    } answer_t;

    typedef struct packed {
        logic [31:0] total_nodes;
        logic [15:0] node_size;
        logic [4:0]  blk_log2;
        logic [31:0] catalog_blocks;
        logic [31:0] volume_blocks;
    } volume_cfg_t;

    typedef struct packed {
        logic        is_cfg;
        volume_cfg_t cfg;
        request_t    req;
        logic        typed;
        answer_t     ans;
    } step_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr       = '0;
    logic [31:0]           cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_func         = 1'b0;
    logic [2:0]            s_slot_index   = '0;
    logic [31:0]           s_slot_start   = '0;
    logic [31:0]           s_slot_count   = '0;
    logic [31:0]           s_node_number  = '0;
    logic                  m_ready        = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [3:0]            m_status;
    logic [51:0]           m_byte_offset;
    logic [2:0]            m_extent_used;
    logic [31:0]           m_volume_block;

    volume_cfg_t cfg_shadow;
    logic [31:0] slot_start_tbl [EXTENT_SLOTS];
    logic [31:0] slot_count_tbl [EXTENT_SLOTS];
    answer_t     pending_answers [$];
    step_t       directed_steps [$];

    int errors       = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit choke_req    = 1'b0;
    bit choke_done   = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    btree_node_extent_translator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot_index   (s_slot_index),
        .s_slot_start   (s_slot_start),
        .s_slot_count   (s_slot_count),
        .s_node_number  (s_node_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_byte_offset  (m_byte_offset),
        .m_extent_used  (m_extent_used),
        .m_volume_block (m_volume_block)
    );

    function automatic int unsigned block_shift(logic [4:0] raw);
        int unsigned lg;
        lg = raw;
        if (lg < BLK_SIZE_LOG2_MIN) lg = BLK_SIZE_LOG2_MIN;
        if (lg > BLK_SIZE_LOG2_MAX) lg = BLK_SIZE_LOG2_MAX;
        return lg;
    endfunction

    function automatic answer_t locate_node(logic [31:0] node);
        answer_t     a;
        int unsigned lg;
        logic [63:0] bsize, cat_off, blk, in_blk, vol_blk, offset;
        bit          found;
        logic [2:0]  used;
        int          i;
        a       = '0;
        found   = 1'b0;
        used    = '0;
        vol_blk = '0;
        if (node >= cfg_shadow.total_nodes) begin
            a.status = STAT_NODE_RANGE;
            return a;
        end
        lg    = block_shift(cfg_shadow.blk_log2);
        bsize = 64'd1 << lg;
        if (64'(cfg_shadow.node_size) > bsize) begin
            a.status = STAT_NODE_EXCEEDS_BLOCK;
            return a;
        end
        cat_off = 64'(node) * 64'(cfg_shadow.node_size);
        blk     = cat_off >> lg;
        in_blk  = cat_off & (bsize - 64'd1);
        if (blk >= 64'(cfg_shadow.catalog_blocks)) begin
            a.status = STAT_BEYOND_FORK;
            return a;
        end
        for (i = 0; i < EXTENT_SLOTS; i++) begin
            if (slot_start_tbl[i] == 0 || slot_count_tbl[i] == 0) begin
                a.status = STAT_EMPTY_EXTENT;
                return a;
            end
            if (slot_start_tbl[i][ILLEGAL_BIT] && slot_count_tbl[i][ILLEGAL_BIT]) begin
                a.status = STAT_ILLEGAL_EXTENT;
                return a;
            end
            if (blk < 64'(slot_count_tbl[i])) begin
                vol_blk = 64'(slot_start_tbl[i]) + blk;
                used    = 3'(i);
                found   = 1'b1;
                break;
            end
            blk = blk - 64'(slot_count_tbl[i]);
        end
        if (!found) begin
            a.status = STAT_NOT_IN_EXTENTS;
            return a;
        end
        if (vol_blk >= 64'(cfg_shadow.volume_blocks)) begin
            a.status = STAT_PAST_VOLUME;
            return a;
        end
        offset = (vol_blk << lg) + in_blk;
        if (offset == 0) begin
            a.status = STAT_ZERO_OFFSET;
            return a;
        end
        a.status       = STAT_OK;
        a.byte_offset  = offset[51:0];
        a.extent_used  = used;
        a.volume_block = vol_blk[31:0];
        return a;
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        a        = '0;
        a.status = STAT_OK;
        if (r.func == FUNC_WRITE_SLOT) begin
            if (int'(r.slot_index) < EXTENT_SLOTS) begin
                slot_start_tbl[r.slot_index] = r.slot_start;
                slot_count_tbl[r.slot_index] = r.slot_count;
            end
            return a;
        end
        return locate_node(r.node_number);
    endfunction

    function automatic void add_cfg(logic [31:0] tn, logic [15:0] ns, logic [4:0] lg,
                                    logic [31:0] cb, logic [31:0] vb);
        step_t s;
        s     = '0;
        s.is_cfg = 1'b1;
        s.cfg = '{total_nodes: tn, node_size: ns, blk_log2: lg,
                  catalog_blocks: cb, volume_blocks: vb};
        directed_steps.push_back(s);
    endfunction

    function automatic void add_write(logic [2:0] idx, logic [31:0] start, logic [31:0] count);
        step_t s;
        s                = '0;
        s.req.func       = FUNC_WRITE_SLOT;
        s.req.slot_index = idx;
        s.req.slot_start = start;
        s.req.slot_count = count;
        s.typed          = 1'b1;
        s.ans.status     = STAT_OK;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_lookup(logic [31:0] node, logic typed, status_t st);
        step_t s;
        s                 = '0;
        s.req.func        = FUNC_TRANSLATE;
        s.req.node_number = node;
        s.typed           = typed;
        s.ans.status      = st;
        directed_steps.push_back(s);
    endfunction

    function automatic volume_cfg_t random_config();
        volume_cfg_t c;
        int unsigned lg;
        if ($urandom_range(0, 9) == 0) c.blk_log2 = 5'($urandom);
        else                           c.blk_log2 = 5'($urandom_range(9, 20));
        lg = block_shift(c.blk_log2);
        case ($urandom_range(0, 9))
            0:       c.node_size = 16'($urandom);
            1:       c.node_size = 16'h8000;
            default: c.node_size = 16'd1 << $urandom_range(9, (lg < 15) ? lg : 15);
        endcase
        case ($urandom_range(0, 4))
            0:       c.total_nodes = $urandom;
            1:       c.total_nodes = $urandom_range(0, 2000);
            default: c.total_nodes = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(0, 3))
            0:       c.catalog_blocks = $urandom_range(0, 600);
            1:       c.catalog_blocks = $urandom;
            default: c.catalog_blocks = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(0, 3))
            0:       c.volume_blocks = $urandom_range(0, 32'h0020_0000);
            1:       c.volume_blocks = $urandom;
            default: c.volume_blocks = 32'hFFFF_FFFF;
        endcase
        return c;
    endfunction

    function automatic request_t random_write(logic tidy, logic [2:0] idx);
        request_t    r;
        logic [31:0] mark;
        mark          = 32'd1 << ILLEGAL_BIT;
        r.func        = FUNC_WRITE_SLOT;
        r.slot_index  = idx;
        r.node_number = $urandom;
        if (tidy) begin
            r.slot_start = $urandom_range(1, 32'h0010_0000);
            r.slot_count = $urandom_range(1, 64);
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    r.slot_start = $urandom;
                    r.slot_count = $urandom;
                end
                1: begin
                    r.slot_start = '0;
                    r.slot_count = $urandom_range(1, 64);
                end
                2: begin
                    r.slot_start = $urandom_range(1, 32'h0010_0000);
                    r.slot_count = '0;
                end
                default: begin
                    r.slot_start = $urandom | mark;
                    r.slot_count = 32'($urandom_range(1, 64)) | mark;
                end
            endcase
        end
        return r;
    endfunction

    function automatic request_t random_lookup();
        request_t    r;
        logic [63:0] covered, reach;
        int          i;
        r.func       = FUNC_TRANSLATE;
        r.slot_index = 3'($urandom);
        r.slot_start = $urandom;
        r.slot_count = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            r.node_number = $urandom;
            return r;
        end
        // Aim at nodes that land inside the leading run of usable extents.
        covered = '0;
        for (i = 0; i < EXTENT_SLOTS; i++) begin
            if (slot_start_tbl[i] == 0 || slot_count_tbl[i] == 0) break;
            if (slot_start_tbl[i][ILLEGAL_BIT] && slot_count_tbl[i][ILLEGAL_BIT]) break;
            covered = covered + 64'(slot_count_tbl[i]);
        end
        reach = ((covered + 64'd2) << block_shift(cfg_shadow.blk_log2))
                / ((cfg_shadow.node_size == 0) ? 64'd1 : 64'(cfg_shadow.node_size));
        if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
        r.node_number = $urandom_range(0, reach[31:0]);
        return r;
    endfunction

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(input volume_cfg_t c);
        put_reg(CFG_TOTAL_NODES, c.total_nodes);
        put_reg(CFG_NODE_SIZE, {16'($urandom), c.node_size});
        put_reg(CFG_BLOCK_SIZE_LOG2, {27'($urandom), c.blk_log2});
        put_reg(CFG_CATALOG_BLOCKS, c.catalog_blocks);
        put_reg(CFG_VOLUME_BLOCKS, c.volume_blocks);
        cfg_wr_en  <= 1'b0;
        cfg_shadow  = c;
    endtask

    task automatic offer(input request_t r, input logic typed, input answer_t typed_ans);
        answer_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= r.func;
        s_slot_index  <= r.slot_index;
        s_slot_start  <= r.slot_start;
        s_slot_count  <= r.slot_count;
        s_node_number <= r.node_number;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(r);
        pending_answers.push_back(typed ? typed_ans : predicted);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_batch(input int n);
        int k;
        if ($urandom_range(0, 4) != 0)
            for (k = 0; k < EXTENT_SLOTS; k++) offer(random_write(1'b1, 3'(k)), 1'b0, '0);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 20)
                offer(random_write($urandom_range(0, 9) < 7, 3'($urandom)), 1'b0, '0);
            else
                offer(random_lookup(), 1'b0, '0);
        end
    endtask

    task automatic note_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with no transaction outstanding, status expected none got %0d",
                         $time, m_status);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                note_field("status", 64'(want.status), 64'(m_status));
                note_field("byte_offset", 64'(want.byte_offset), 64'(m_byte_offset));
                note_field("extent_used", 64'(want.extent_used), 64'(m_extent_used));
                note_field("volume_block", 64'(want.volume_block), 64'(m_volume_block));
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left  = hold_left - 1;
        end else if (choke_req && !choke_done) begin
            m_ready    <= 1'b0;
            hold_left   = HOLD_CYCLES;
            choke_done  = 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        step_t st;
        int    p, b, i;
        cfg_shadow = '{total_nodes: 32'd0, node_size: 16'd4096, blk_log2: 5'd12,
                       catalog_blocks: 32'd0, volume_blocks: 32'd0};
        for (i = 0; i < EXTENT_SLOTS; i++) begin
            slot_start_tbl[i] = '0;
            slot_count_tbl[i] = '0;
        end

        // Reset values: no nodes, so every lookup is out of range.
        add_lookup(32'd0, 1'b1, STAT_NODE_RANGE);
        add_lookup(32'hFFFF_FFFF, 1'b1, STAT_NODE_RANGE);
        add_write(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cfg(32'hFFFF_FFFF, 16'd4096, 5'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_lookup(32'd5, 1'b1, STAT_EMPTY_EXTENT);
        add_write(3'd0, 32'd100, 32'd10);
        add_lookup(32'd3, 1'b0, STAT_OK);
        add_lookup(32'd0, 1'b0, STAT_OK);
        add_lookup(32'd10, 1'b1, STAT_EMPTY_EXTENT);
        add_write(3'd1, 32'h1000_0005, 32'h1000_0002);
        add_lookup(32'd10, 1'b1, STAT_ILLEGAL_EXTENT);
        add_write(3'd1, 32'h1000_0005, 32'd2);
        add_lookup(32'd11, 1'b0, STAT_OK);
        add_write(3'd2, 32'd300, 32'd4);
        add_write(3'd3, 32'd400, 32'd4);
        add_write(3'd4, 32'd500, 32'd4);
        add_write(3'd5, 32'd600, 32'd4);
        add_write(3'd6, 32'd700, 32'd4);
        add_write(3'd7, 32'hFFFF_FF00, 32'd3);
        add_lookup(32'd33, 1'b0, STAT_OK);
        add_lookup(32'd40, 1'b1, STAT_NOT_IN_EXTENTS);
        add_cfg(32'hFFFF_FFFF, 16'd32768, 5'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_lookup(32'd0, 1'b1, STAT_NODE_EXCEEDS_BLOCK);
        // Zero node size and a block size below range.
        add_cfg(32'd1000, 16'd0, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_lookup(32'd999, 1'b0, STAT_OK);
        // Node size that is not a power of two and a block size above range.
        add_cfg(32'hFFFF_FFFF, 16'd3000, 5'd31, 32'd5, 32'h1000_0010);
        add_lookup(32'd8, 1'b0, STAT_OK);
        add_lookup(32'hFFFF_FFFE, 1'b1, STAT_BEYOND_FORK);
        add_cfg(32'hFFFF_FFFF, 16'd512, 5'd20, 32'hFFFF_FFFF, 32'd50);
        add_lookup(32'd0, 1'b1, STAT_PAST_VOLUME);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[j]) begin
            st = directed_steps[j];
            if (st.is_cfg) begin
                drain();
                set_config(st.cfg);
            end else begin
                offer(st.req, st.typed, st.ans);
            end
        end

        for (p = 0; p < 3; p++) begin
            drain();
            case (p)
                0: begin
                    tx_idle_pct <= 20;
                    rx_idle_pct <= 76;
                end
                1: begin
                    tx_idle_pct <= 76;
                    rx_idle_pct <= 20;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                    choke_req   <= 1'b1;
                end
            endcase
            for (b = 0; b < BATCHES; b++) begin
                drain();
                set_config(random_config());
                run_batch(BATCH_ITEMS);
            end
        end

        drain();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
